// ===== design/gravity_verlet_body_step_unit_defines.svh =====
// Assertion macros shared by the checker of the body step unit.
// Used by design/gvb_checker.sv; needs signals named clock and reset in scope.
`ifndef GRAVITY_VERLET_BODY_STEP_UNIT_DEFINES_SVH
`define GRAVITY_VERLET_BODY_STEP_UNIT_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define GVB_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gvb checker: next-cycle property failed");

// Consequent checked in the same cycle as the antecedent.
`define GVB_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gvb checker: same-cycle property failed");

`endif

// ===== design/gvb_pkg.sv =====
// Package of the gravity body step unit: types, constants and helper functions.
// No dependencies; used by every module of the block except gvb_iter.
`timescale 1ns / 1ps

package gvb_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int CNT_W        = $clog2(CORDIC_STEPS);

   localparam logic [30:0] TIME_STEP_RST    = 31'd1092;
   localparam logic [30:0] GRAV_CONST_RST   = 31'd65536;
   localparam logic [30:0] THRUST_ACCEL_RST = 31'd3276800;

   localparam logic [30:0] Q_CAP = 31'h7FFF_FFFF;
   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
   localparam logic signed [33:0] CORDIC_X0 = 34'sh0_26DD_3B6A;

   localparam logic signed [16:0] QUARTER_TURN = 17'sd16384;
   localparam logic signed [16:0] HALF_TURN    = 17'sd32768;

   typedef enum logic [2:0] {
      OP_BEGIN_STEP = 3'd0,
      OP_BODY       = 3'd1,
      OP_END_STEP   = 3'd2,
      OP_THRUST     = 3'd3,
      OP_ROTATE     = 3'd4,
      OP_RESTART    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      CSR_TIME_STEP    = 3'd0,
      CSR_GRAV_CONST   = 3'd1,
      CSR_THRUST_ACCEL = 3'd2,
      CSR_START_POS_X  = 3'd3,
      CSR_START_POS_Y  = 3'd4,
      CSR_START_VEL_X  = 3'd5,
      CSR_START_VEL_Y  = 3'd6
   } csr_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] source_x;
      logic signed [31:0] source_y;
      logic [30:0]        source_mass;
      logic [15:0]        angle_delta;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic               saturated;
   } rsp_type;

   typedef enum logic [4:0] {
      UOP_NONE,
      UOP_B1, UOP_B2, UOP_B3,
      UOP_G0, UOP_G1, UOP_G2, UOP_G3,
      UOP_SQRT_GO, UOP_SQRT_TAKE,
      UOP_DIVM_GO, UOP_DIVM_TAKE,
      UOP_DIVX_GO, UOP_DIVX_TAKE,
      UOP_DIVY_GO, UOP_DIVY_TAKE,
      UOP_G8, UOP_G9,
      UOP_T0, UOP_T_ITER, UOP_T1, UOP_T2,
      UOP_E1, UOP_E2, UOP_EMIT,
      UOP_ROTATE, UOP_RESTART
   } uop_type;

   typedef struct packed {
      uop_type uop;
      logic    iter_start;
   } cmd_type;

   typedef struct packed {
      logic iter_busy;
      logic dist_zero;
      logic cordic_last;
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_B2, S_B3,
      S_G1, S_G2, S_G3,
      S_SQRT_GO, S_SQRT_WAIT,
      S_DIVM_GO, S_DIVM_WAIT,
      S_DIVX_GO, S_DIVX_WAIT,
      S_DIVY_GO, S_DIVY_WAIT,
      S_G8, S_G9,
      S_T_ITER, S_T1, S_T2,
      S_E2, S_EMIT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > SAT_MAX) return 32'sh7FFF_FFFF;
      if (v < SAT_MIN) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic sat_hit(input logic signed [63:0] v);
      return (v > SAT_MAX) || (v < SAT_MIN);
   endfunction

   // Arctangent of 2^-i as a fraction of a turn scaled by 2^32.
   function automatic logic [29:0] atan_turn(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0:    r = 30'h2000_0000;
         5'd1:    r = 30'h12E4_051E;
         5'd2:    r = 30'h09FB_385B;
         5'd3:    r = 30'h0511_11D4;
         5'd4:    r = 30'h028B_0D43;
         5'd5:    r = 30'h0145_D7E1;
         5'd6:    r = 30'h00A2_F61E;
         5'd7:    r = 30'h0051_7C55;
         5'd8:    r = 30'h0028_BE53;
         5'd9:    r = 30'h0014_5F2F;
         5'd10:   r = 30'h000A_2F98;
         5'd11:   r = 30'h0005_17CC;
         5'd12:   r = 30'h0002_8BE6;
         5'd13:   r = 30'h0001_45F3;
         5'd14:   r = 30'h0000_A2F9;
         5'd15:   r = 30'h0000_517C;
         5'd16:   r = 30'h0000_28BE;
         5'd17:   r = 30'h0000_145F;
         5'd18:   r = 30'h0000_0A2F;
         5'd19:   r = 30'h0000_0517;
         5'd20:   r = 30'h0000_028B;
         5'd21:   r = 30'h0000_0145;
         5'd22:   r = 30'h0000_00A2;
         5'd23:   r = 30'h0000_0051;
         default: r = 30'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/gvb_iter.sv =====
// Shared iterative unit: restoring divider (one quotient bit per cycle) and
// digit-by-digit square root (two radicand bits per cycle).
`timescale 1ns / 1ps

module gvb_iter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        mode_sqrt,
   input  logic [79:0] operand_a,
   input  logic [63:0] operand_b,
   output logic        busy,
   output logic [31:0] result,
   output logic        overflow
);

   localparam logic [6:0] DIV_STEPS  = 7'd80;
   localparam logic [6:0] SQRT_STEPS = 7'd32;

   logic        busy_ff, busy_in;
   logic        sqrt_ff, sqrt_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [79:0] num_ff, num_in;
   logic [65:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [31:0] res_ff, res_in;
   logic        ovf_ff, ovf_in;

   always_comb begin
      logic [64:0] div_trial;
      logic [65:0] sq_trial;
      logic [65:0] sq_root;
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      res_in  = res_ff;
      ovf_in  = ovf_ff;
      div_trial = {rem_ff[63:0], num_ff[79]};
      sq_trial  = {rem_ff[63:0], num_ff[79:78]};
      sq_root   = {32'b0, res_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         sqrt_in = mode_sqrt;
         cnt_in  = '0;
         num_in  = mode_sqrt ? {operand_a[63:0], 16'b0} : operand_a;
         rem_in  = '0;
         den_in  = operand_b;
         res_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (sqrt_ff) begin
            num_in = {num_ff[77:0], 2'b00};
            if (sq_trial >= sq_root) begin
               rem_in = sq_trial - sq_root;
               res_in = {res_ff[30:0], 1'b1};
            end else begin
               rem_in = sq_trial;
               res_in = {res_ff[30:0], 1'b0};
            end
            if (cnt_ff == SQRT_STEPS - 7'd1) busy_in = 1'b0;
         end else begin
            num_in = {num_ff[78:0], 1'b0};
            // A one shifted past bit 30 means the quotient exceeds the cap.
            ovf_in = ovf_ff | res_ff[30];
            if (div_trial >= {1'b0, den_ff}) begin
               rem_in = {2'b0, 64'(div_trial - {1'b0, den_ff})};
               res_in = {res_ff[30:0], 1'b1};
            end else begin
               rem_in = {2'b0, div_trial[63:0]};
               res_in = {res_ff[30:0], 1'b0};
            end
            if (cnt_ff == DIV_STEPS - 7'd1) busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      sqrt_ff <= sqrt_in;
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      res_ff  <= res_in;
      ovf_ff  <= ovf_in;
   end

   assign busy     = busy_ff;
   assign result   = res_ff;
   assign overflow = ovf_ff;

endmodule

// ===== design/gvb_dpath.sv =====
// Datapath of the body step unit: body state, configuration registers,
// multipliers, CORDIC iteration and result register. Uses gvb_pkg, gvb_iter.
`timescale 1ns / 1ps

module gvb_dpath (
   input  logic                clock,
   input  logic                reset,
   input  gvb_pkg::cmd_type    cmd,
   input  gvb_pkg::req_type    req_data,
   input  logic                csr_valid,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output gvb_pkg::status_type status,
   output gvb_pkg::rsp_type    rsp_data
);

   logic [30:0] dt_ff, g_ff, ta_ff;
   logic signed [31:0] spx_ff, spy_ff, svx_ff, svy_ff;

   logic signed [31:0] pos_ff[2], pos_in[2];
   logic signed [31:0] vel_ff[2], vel_in[2];
   logic signed [31:0] anow_ff[2], anow_in[2];
   logic signed [31:0] aprev_ff[2], aprev_in[2];
   logic [15:0] heading_ff, heading_in;
   logic        clip_ff, clip_in;

   logic signed [63:0] t1_ff[2], t1_in[2];
   logic signed [63:0] t2_ff[2], t2_in[2];
   logic signed [32:0] dx_ff[2], dx_in[2];
   logic [30:0] mag_ff[2], mag_in[2];
   logic        neg_ff[2], neg_in[2];
   logic [16:0] u_ff[2], u_in[2];
   logic        half_ff, half_in;
   logic [30:0] mass_ff, mass_in;
   logic [62:0] d2_ff, d2_in;
   logic [61:0] gm_ff, gm_in;
   logic [31:0] root_ff, root_in;
   logic [30:0] m_ff, m_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic        flip_ff, flip_in;
   logic [gvb_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   gvb_pkg::rsp_type rsp_ff, rsp_in;

   logic        iter_sqrt;
   logic [79:0] iter_a;
   logic [63:0] iter_b;
   logic        iter_busy;
   logic [31:0] iter_res;
   logic        iter_ovf;

   gvb_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.iter_start),
      .mode_sqrt (iter_sqrt),
      .operand_a (iter_a),
      .operand_b (iter_b),
      .busy      (iter_busy),
      .result    (iter_res),
      .overflow  (iter_ovf)
   );

   always_comb begin
      iter_sqrt = 1'b0;
      iter_a    = 80'(gm_ff) << (half_ff ? gvb_pkg::FRAC_BITS - 2 : gvb_pkg::FRAC_BITS);
      iter_b    = {1'b0, d2_ff};
      case (cmd.uop)
         gvb_pkg::UOP_SQRT_GO: begin
            iter_sqrt = 1'b1;
            iter_a    = {17'b0, d2_ff};
         end
         gvb_pkg::UOP_DIVX_GO: begin
            iter_a = 80'(mag_ff[0]) << gvb_pkg::FRAC_BITS;
            iter_b = 64'(root_ff);
         end
         gvb_pkg::UOP_DIVY_GO: begin
            iter_a = 80'(mag_ff[1]) << gvb_pkg::FRAC_BITS;
            iter_b = 64'(root_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      logic signed [63:0] h;
      logic signed [63:0] sum;
      logic signed [63:0] add;
      logic signed [32:0] s33;
      logic [32:0]        a33[2];
      logic               big;
      logic [61:0]        sq;
      logic [47:0]        mu;
      logic signed [16:0] t17;
      logic signed [33:0] sn, cs;
      logic signed [33:0] ysh, xsh, at;
      for (int k = 0; k < 2; k++) begin
         pos_in[k]   = pos_ff[k];
         vel_in[k]   = vel_ff[k];
         anow_in[k]  = anow_ff[k];
         aprev_in[k] = aprev_ff[k];
         t1_in[k]    = t1_ff[k];
         t2_in[k]    = t2_ff[k];
         dx_in[k]    = dx_ff[k];
         mag_in[k]   = mag_ff[k];
         neg_in[k]   = neg_ff[k];
         u_in[k]     = u_ff[k];
         a33[k]      = dx_ff[k][32] ? 33'(-dx_ff[k]) : 33'(dx_ff[k]);
      end
      heading_in = heading_ff;
      clip_in    = clip_ff;
      half_in    = half_ff;
      mass_in    = mass_ff;
      d2_in      = d2_ff;
      gm_in      = gm_ff;
      root_in    = root_ff;
      m_in       = m_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cz_in      = cz_ff;
      flip_in    = flip_ff;
      cnt_in     = cnt_ff;
      rsp_in     = rsp_ff;
      h = '0; sum = '0; add = '0; s33 = '0; sq = '0; mu = '0;
      t17 = '0; sn = '0; cs = '0; ysh = '0; xsh = '0; at = '0;
      big = (a33[0][32:31] != 2'b00) || (a33[1][32:31] != 2'b00);
      case (cmd.uop)
         gvb_pkg::UOP_B1: begin
            for (int k = 0; k < 2; k++) begin
               t1_in[k] = vel_ff[k] * $signed({1'b0, dt_ff});
               t2_in[k] = aprev_ff[k] * $signed({1'b0, dt_ff});
            end
         end
         gvb_pkg::UOP_B2: begin
            for (int k = 0; k < 2; k++) begin
               h = 64'(gvb_pkg::sat32(t2_ff[k] >>> gvb_pkg::FRAC_BITS));
               if (gvb_pkg::sat_hit(t2_ff[k] >>> gvb_pkg::FRAC_BITS)) clip_in = 1'b1;
               t2_in[k] = h * $signed({1'b0, dt_ff});
            end
         end
         gvb_pkg::UOP_B3: begin
            for (int k = 0; k < 2; k++) begin
               sum = pos_ff[k] + (t1_ff[k] >>> gvb_pkg::FRAC_BITS)
                   + (t2_ff[k] >>> (gvb_pkg::FRAC_BITS + 1));
               pos_in[k] = gvb_pkg::sat32(sum);
               if (gvb_pkg::sat_hit(sum)) clip_in = 1'b1;
            end
         end
         gvb_pkg::UOP_G0: begin
            dx_in[0] = req_data.source_x - pos_ff[0];
            dx_in[1] = req_data.source_y - pos_ff[1];
            mass_in  = req_data.source_mass;
         end
         gvb_pkg::UOP_G1: begin
            // Far sources are halved on both axes; the divide shift folds it back.
            half_in = big;
            for (int k = 0; k < 2; k++) begin
               mag_in[k] = big ? a33[k][31:1] : a33[k][30:0];
               neg_in[k] = dx_ff[k][32];
            end
         end
         gvb_pkg::UOP_G2: begin
            for (int k = 0; k < 2; k++) begin
               sq = {31'b0, mag_ff[k]} * {31'b0, mag_ff[k]};
               t1_in[k] = $signed({2'b0, sq});
            end
            sq = {31'b0, g_ff} * {31'b0, mass_ff};
            t2_in[0] = $signed({2'b0, sq});
         end
         gvb_pkg::UOP_G3: begin
            d2_in = {1'b0, t1_ff[0][61:0]} + {1'b0, t1_ff[1][61:0]};
            gm_in = t2_ff[0][61:0];
         end
         gvb_pkg::UOP_SQRT_TAKE: root_in = iter_res;
         gvb_pkg::UOP_DIVM_TAKE: begin
            m_in = iter_ovf ? gvb_pkg::Q_CAP : iter_res[30:0];
            if (!iter_busy && iter_ovf) clip_in = 1'b1;
         end
         gvb_pkg::UOP_DIVX_TAKE: u_in[0] = iter_res[16:0];
         gvb_pkg::UOP_DIVY_TAKE: u_in[1] = iter_res[16:0];
         gvb_pkg::UOP_G8: begin
            for (int k = 0; k < 2; k++) begin
               mu = {17'b0, m_ff} * {31'b0, u_ff[k]};
               t1_in[k] = $signed({16'b0, mu});
            end
         end
         gvb_pkg::UOP_G9: begin
            for (int k = 0; k < 2; k++) begin
               add = $signed({32'b0, t1_ff[k][47:16]});
               if (neg_ff[k]) add = -add;
               sum = anow_ff[k] + add;
               anow_in[k] = gvb_pkg::sat32(sum);
               if (gvb_pkg::sat_hit(sum)) clip_in = 1'b1;
            end
         end
         gvb_pkg::UOP_T0: begin
            // Fold the heading into the CORDIC range; the vector is negated later.
            t17 = 17'($signed(heading_ff));
            flip_in = 1'b0;
            if (t17 > gvb_pkg::QUARTER_TURN) begin
               t17 = t17 - gvb_pkg::HALF_TURN;
               flip_in = 1'b1;
            end else if (t17 < -gvb_pkg::QUARTER_TURN) begin
               t17 = t17 + gvb_pkg::HALF_TURN;
               flip_in = 1'b1;
            end
            cz_in  = $signed({t17[16], t17, 16'b0});
            cx_in  = gvb_pkg::CORDIC_X0;
            cy_in  = '0;
            cnt_in = '0;
         end
         gvb_pkg::UOP_T_ITER: begin
            ysh = cy_ff >>> cnt_ff;
            xsh = cx_ff >>> cnt_ff;
            at  = $signed({4'b0, gvb_pkg::atan_turn(5'(cnt_ff))});
            if (!cz_ff[33]) begin
               cx_in = cx_ff - ysh;
               cy_in = cy_ff + xsh;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ysh;
               cy_in = cy_ff - xsh;
               cz_in = cz_ff + at;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         gvb_pkg::UOP_T1: begin
            sn = flip_ff ? -cy_ff : cy_ff;
            cs = flip_ff ? -cx_ff : cx_ff;
            t1_in[0] = $signed({1'b0, ta_ff}) * sn;
            t1_in[1] = $signed({1'b0, ta_ff}) * (-cs);
         end
         gvb_pkg::UOP_T2: begin
            for (int k = 0; k < 2; k++) begin
               sum = anow_ff[k] + (t1_ff[k] >>> 30);
               anow_in[k] = gvb_pkg::sat32(sum);
               if (gvb_pkg::sat_hit(sum)) clip_in = 1'b1;
            end
         end
         gvb_pkg::UOP_E1: begin
            for (int k = 0; k < 2; k++) begin
               s33 = aprev_ff[k] + anow_ff[k];
               t1_in[k] = s33 * $signed({1'b0, dt_ff});
            end
         end
         gvb_pkg::UOP_E2: begin
            for (int k = 0; k < 2; k++) begin
               sum = vel_ff[k] + (t1_ff[k] >>> (gvb_pkg::FRAC_BITS + 1));
               vel_in[k] = gvb_pkg::sat32(sum);
               if (gvb_pkg::sat_hit(sum)) clip_in = 1'b1;
               aprev_in[k] = anow_ff[k];
               anow_in[k]  = '0;
            end
         end
         gvb_pkg::UOP_EMIT: begin
            rsp_in.pos_x     = pos_ff[0];
            rsp_in.pos_y     = pos_ff[1];
            rsp_in.vel_x     = vel_ff[0];
            rsp_in.vel_y     = vel_ff[1];
            rsp_in.saturated = clip_ff;
            clip_in = 1'b0;
         end
         gvb_pkg::UOP_ROTATE: heading_in = heading_ff + req_data.angle_delta;
         gvb_pkg::UOP_RESTART: begin
            pos_in[0] = spx_ff;
            pos_in[1] = spy_ff;
            vel_in[0] = svx_ff;
            vel_in[1] = svy_ff;
            for (int k = 0; k < 2; k++) begin
               anow_in[k]  = '0;
               aprev_in[k] = '0;
            end
            heading_in = '0;
            clip_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff  <= gvb_pkg::TIME_STEP_RST;
         g_ff   <= gvb_pkg::GRAV_CONST_RST;
         ta_ff  <= gvb_pkg::THRUST_ACCEL_RST;
         spx_ff <= '0;
         spy_ff <= '0;
         svx_ff <= '0;
         svy_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            gvb_pkg::CSR_TIME_STEP:    dt_ff  <= csr_wdata[30:0];
            gvb_pkg::CSR_GRAV_CONST:   g_ff   <= csr_wdata[30:0];
            gvb_pkg::CSR_THRUST_ACCEL: ta_ff  <= csr_wdata[30:0];
            gvb_pkg::CSR_START_POS_X:  spx_ff <= csr_wdata;
            gvb_pkg::CSR_START_POS_Y:  spy_ff <= csr_wdata;
            gvb_pkg::CSR_START_VEL_X:  svx_ff <= csr_wdata;
            gvb_pkg::CSR_START_VEL_Y:  svy_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            pos_ff[k]   <= '0;
            vel_ff[k]   <= '0;
            anow_ff[k]  <= '0;
            aprev_ff[k] <= '0;
         end
         heading_ff <= '0;
         clip_ff    <= 1'b0;
      end else begin
         for (int k = 0; k < 2; k++) begin
            pos_ff[k]   <= pos_in[k];
            vel_ff[k]   <= vel_in[k];
            anow_ff[k]  <= anow_in[k];
            aprev_ff[k] <= aprev_in[k];
         end
         heading_ff <= heading_in;
         clip_ff    <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 2; k++) begin
         t1_ff[k]  <= t1_in[k];
         t2_ff[k]  <= t2_in[k];
         dx_ff[k]  <= dx_in[k];
         mag_ff[k] <= mag_in[k];
         neg_ff[k] <= neg_in[k];
         u_ff[k]   <= u_in[k];
      end
      half_ff <= half_in;
      mass_ff <= mass_in;
      d2_ff   <= d2_in;
      gm_ff   <= gm_in;
      root_ff <= root_in;
      m_ff    <= m_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      flip_ff <= flip_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign status.iter_busy   = iter_busy;
   assign status.dist_zero   = (dx_ff[0] == '0) && (dx_ff[1] == '0);
   assign status.cordic_last = (cnt_ff == gvb_pkg::CNT_W'(gvb_pkg::CORDIC_STEPS - 1));
   assign rsp_data = rsp_ff;

endmodule

// ===== design/gvb_ctrl.sv =====
// Controller of the body step unit: sequences the datapath per item and owns
// the input stall and the result valid flag. Uses gvb_pkg.
`timescale 1ns / 1ps

module gvb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [2:0]          req_op,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  gvb_pkg::status_type status,
   output gvb_pkg::cmd_type    cmd
);

   gvb_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gvb_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  gvb_pkg::OP_BEGIN_STEP: state_in = gvb_pkg::S_B2;
                  gvb_pkg::OP_BODY:       state_in = gvb_pkg::S_G1;
                  gvb_pkg::OP_END_STEP:   state_in = gvb_pkg::S_E2;
                  gvb_pkg::OP_THRUST:     state_in = gvb_pkg::S_T_ITER;
                  default:                state_in = gvb_pkg::S_IDLE;
               endcase
            end
         end
         gvb_pkg::S_B2:      state_in = gvb_pkg::S_B3;
         gvb_pkg::S_B3:      state_in = gvb_pkg::S_IDLE;
         gvb_pkg::S_G1:      state_in = status.dist_zero ? gvb_pkg::S_IDLE : gvb_pkg::S_G2;
         gvb_pkg::S_G2:      state_in = gvb_pkg::S_G3;
         gvb_pkg::S_G3:      state_in = gvb_pkg::S_SQRT_GO;
         gvb_pkg::S_SQRT_GO: state_in = gvb_pkg::S_SQRT_WAIT;
         gvb_pkg::S_SQRT_WAIT:
            if (!status.iter_busy) state_in = gvb_pkg::S_DIVM_GO;
         gvb_pkg::S_DIVM_GO: state_in = gvb_pkg::S_DIVM_WAIT;
         gvb_pkg::S_DIVM_WAIT:
            if (!status.iter_busy) state_in = gvb_pkg::S_DIVX_GO;
         gvb_pkg::S_DIVX_GO: state_in = gvb_pkg::S_DIVX_WAIT;
         gvb_pkg::S_DIVX_WAIT:
            if (!status.iter_busy) state_in = gvb_pkg::S_DIVY_GO;
         gvb_pkg::S_DIVY_GO: state_in = gvb_pkg::S_DIVY_WAIT;
         gvb_pkg::S_DIVY_WAIT:
            if (!status.iter_busy) state_in = gvb_pkg::S_G8;
         gvb_pkg::S_G8:      state_in = gvb_pkg::S_G9;
         gvb_pkg::S_G9:      state_in = gvb_pkg::S_IDLE;
         gvb_pkg::S_T_ITER:
            if (status.cordic_last) state_in = gvb_pkg::S_T1;
         gvb_pkg::S_T1:      state_in = gvb_pkg::S_T2;
         gvb_pkg::S_T2:      state_in = gvb_pkg::S_IDLE;
         gvb_pkg::S_E2:      state_in = gvb_pkg::S_EMIT;
         gvb_pkg::S_EMIT:
            if (slot_free) state_in = gvb_pkg::S_IDLE;
         default:            state_in = gvb_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.uop        = gvb_pkg::UOP_NONE;
      cmd.iter_start = 1'b0;
      req_stall      = 1'b1;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (state_ff)
         gvb_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (req_op)
                  gvb_pkg::OP_BEGIN_STEP: cmd.uop = gvb_pkg::UOP_B1;
                  gvb_pkg::OP_BODY:       cmd.uop = gvb_pkg::UOP_G0;
                  gvb_pkg::OP_END_STEP:   cmd.uop = gvb_pkg::UOP_E1;
                  gvb_pkg::OP_THRUST:     cmd.uop = gvb_pkg::UOP_T0;
                  gvb_pkg::OP_ROTATE:     cmd.uop = gvb_pkg::UOP_ROTATE;
                  gvb_pkg::OP_RESTART:    cmd.uop = gvb_pkg::UOP_RESTART;
                  default:                cmd.uop = gvb_pkg::UOP_NONE;
               endcase
            end
         end
         gvb_pkg::S_B2: cmd.uop = gvb_pkg::UOP_B2;
         gvb_pkg::S_B3: cmd.uop = gvb_pkg::UOP_B3;
         gvb_pkg::S_G1:
            if (!status.dist_zero) cmd.uop = gvb_pkg::UOP_G1;
         gvb_pkg::S_G2: cmd.uop = gvb_pkg::UOP_G2;
         gvb_pkg::S_G3: cmd.uop = gvb_pkg::UOP_G3;
         gvb_pkg::S_SQRT_GO: begin
            cmd.uop        = gvb_pkg::UOP_SQRT_GO;
            cmd.iter_start = 1'b1;
         end
         gvb_pkg::S_SQRT_WAIT: cmd.uop = gvb_pkg::UOP_SQRT_TAKE;
         gvb_pkg::S_DIVM_GO: begin
            cmd.uop        = gvb_pkg::UOP_DIVM_GO;
            cmd.iter_start = 1'b1;
         end
         gvb_pkg::S_DIVM_WAIT: cmd.uop = gvb_pkg::UOP_DIVM_TAKE;
         gvb_pkg::S_DIVX_GO: begin
            cmd.uop        = gvb_pkg::UOP_DIVX_GO;
            cmd.iter_start = 1'b1;
         end
         gvb_pkg::S_DIVX_WAIT: cmd.uop = gvb_pkg::UOP_DIVX_TAKE;
         gvb_pkg::S_DIVY_GO: begin
            cmd.uop        = gvb_pkg::UOP_DIVY_GO;
            cmd.iter_start = 1'b1;
         end
         gvb_pkg::S_DIVY_WAIT: cmd.uop = gvb_pkg::UOP_DIVY_TAKE;
         gvb_pkg::S_G8:     cmd.uop = gvb_pkg::UOP_G8;
         gvb_pkg::S_G9:     cmd.uop = gvb_pkg::UOP_G9;
         gvb_pkg::S_T_ITER: cmd.uop = gvb_pkg::UOP_T_ITER;
         gvb_pkg::S_T1:     cmd.uop = gvb_pkg::UOP_T1;
         gvb_pkg::S_T2:     cmd.uop = gvb_pkg::UOP_T2;
         gvb_pkg::S_E2:     cmd.uop = gvb_pkg::UOP_E2;
         gvb_pkg::S_EMIT: begin
            // The result register is loaded only once the previous beat has left.
            if (slot_free) begin
               cmd.uop      = gvb_pkg::UOP_EMIT;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd.uop = gvb_pkg::UOP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gvb_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/gravity_verlet_body_step_unit.sv =====
// Velocity Verlet gravity step for one body. Rotate and restart act on acceptance
// and unused codes are dropped; begin_step passes states B2 and B3; thrust runs
// 16 CORDIC rotations; end_step also waits for the result register; body waits on
// the shared iterative unit for a square root and three divides, unless the
// distance is zero. One item at a time. Synchronous active-high reset
// restores register defaults and clears the body state.
`timescale 1ns / 1ps

module gravity_verlet_body_step_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gvb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gvb_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   gvb_pkg::cmd_type    cmd;
   gvb_pkg::status_type status;

   assign csr_ready = 1'b1;

   gvb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gvb_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/gvb_checker.sv =====
// Port-level checker of the body step unit, bound to the top level.
// Uses gvb_pkg and the macros of gravity_verlet_body_step_unit_defines.svh.
`timescale 1ns / 1ps
`include "gravity_verlet_body_step_unit_defines.svh"

module gvb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input gvb_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input gvb_pkg::rsp_type rsp_data
);

   `GVB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `GVB_ASSERT_NEXT(a_end_busy, req_valid && !req_stall && req_data.operation == gvb_pkg::OP_END_STEP, req_stall)
   `GVB_ASSERT_NEXT(a_body_busy, req_valid && !req_stall && req_data.operation == gvb_pkg::OP_BODY, req_stall)
   `GVB_ASSERT_SAME(a_rsp_after_work, $rose(rsp_valid), $past(req_stall))

endmodule

bind gravity_verlet_body_step_unit gvb_checker u_gvb_checker (.*);

// ===== tb/sv/tb_gravity_verlet_body_step_unit.sv =====
// Self-checking testbench of the velocity Verlet body step unit.
// Depends on gvb_pkg and gravity_verlet_body_step_unit; predicts each result in-line.
`timescale 1ns / 1ps

module tb_gravity_verlet_body_step_unit;

   localparam int SETTLE_CYCLES = 400;

   localparam longint ATAN_TURN [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
      64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   gvb_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   gvb_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [2:0]       csr_index;
   logic [31:0]      csr_wdata;

   gravity_verlet_body_step_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata));

   // Predicted body state and register copies.
   longint      pos_q [2];
   longint      vel_q [2];
   longint      acc_now_q [2];
   longint      acc_prev_q [2];
   logic [15:0] heading_q;
   bit          clipped_q;
   logic [30:0] dt_cfg, grav_cfg, thrust_cfg;
   longint      start_cfg [4];

   gvb_pkg::rsp_type step_results_q [$];
   int          errors;
   int          mismatches;
   int          items_sent;
   int          steps_checked;
   int          hold_left;
   bit          calm;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
         clipped_q = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clipped_q = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bit_w;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (n >= root + bit_w) begin
            n    = n - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   // Long division continued for sh fraction bits, capped at 2^31-1.
   function automatic longint unsigned capped_quotient(longint unsigned num, int sh,
                                                       longint unsigned den);
      longint unsigned q, rem;
      q   = num / den;
      rem = num % den;
      for (int i = 0; i < sh; i++) begin
         if (q > 64'h7FFF_FFFF) break;
         rem = rem << 1;
         q   = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q   = q | 1;
         end
      end
      if (q > 64'h7FFF_FFFF) begin
         clipped_q = 1'b1;
         return 64'h7FFF_FFFF;
      end
      return q;
   endfunction

   function automatic void add_gravity(longint sx, longint sy, longint unsigned mass);
      longint          dx, dy, tx, ty;
      longint unsigned ax, ay, d2, root, mag, ux, uy;
      int              halved;
      dx = sx - pos_q[0];
      dy = sy - pos_q[1];
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      halved = 0;
      if (ax == 0 && ay == 0) return;
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
         halved = 1;
         ax = ax >> 1;
         ay = ay >> 1;
      end
      d2   = ax * ax + ay * ay;
      root = int_sqrt(d2);
      mag  = capped_quotient(longint'(grav_cfg) * mass, gvb_pkg::FRAC_BITS - 2 * halved, d2);
      ux   = (ax << gvb_pkg::FRAC_BITS) / root;
      uy   = (ay << gvb_pkg::FRAC_BITS) / root;
      tx   = longint'((mag * ux) >> gvb_pkg::FRAC_BITS);
      ty   = longint'((mag * uy) >> gvb_pkg::FRAC_BITS);
      acc_now_q[0] = clamp32(acc_now_q[0] + ((dx < 0) ? -tx : tx));
      acc_now_q[1] = clamp32(acc_now_q[1] + ((dy < 0) ? -ty : ty));
   endfunction

   function automatic void heading_vector(output longint sn, output longint cs);
      longint ang, x, y, z, nx;
      bit     flip;
      ang  = longint'(heading_q);
      flip = 1'b0;
      x    = 64'h26DD3B6A;
      y    = 0;
      if (ang >= 32768) ang = ang - 65536;
      if (ang > 16384) begin
         ang  = ang - 32768;
         flip = 1'b1;
      end else if (ang < -16384) begin
         ang  = ang + 32768;
         flip = 1'b1;
      end
      z = ang * 65536;
      for (int i = 0; i < gvb_pkg::CORDIC_STEPS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ATAN_TURN[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ATAN_TURN[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      sn = y;
      cs = x;
   endfunction

   function automatic void advance_body(gvb_pkg::req_type it);
      longint  dt, vt, half, at, sum, sn, cs;
      gvb_pkg::rsp_type res;
      dt = longint'(dt_cfg);
      case (it.operation)
         gvb_pkg::OP_BEGIN_STEP: begin
            for (int k = 0; k < 2; k++) begin
               vt   = (vel_q[k] * dt) >>> gvb_pkg::FRAC_BITS;
               half = clamp32((acc_prev_q[k] * dt) >>> gvb_pkg::FRAC_BITS);
               at   = (half * dt) >>> (gvb_pkg::FRAC_BITS + 1);
               pos_q[k] = clamp32(pos_q[k] + vt + at);
            end
         end
         gvb_pkg::OP_BODY: add_gravity(longint'(it.source_x), longint'(it.source_y),
                                       longint'(it.source_mass));
         gvb_pkg::OP_END_STEP: begin
            for (int k = 0; k < 2; k++) begin
               sum = acc_prev_q[k] + acc_now_q[k];
               vel_q[k] = clamp32(vel_q[k] + ((sum * dt) >>> (gvb_pkg::FRAC_BITS + 1)));
               acc_prev_q[k] = acc_now_q[k];
               acc_now_q[k]  = 0;
            end
            res.pos_x     = pos_q[0][31:0];
            res.pos_y     = pos_q[1][31:0];
            res.vel_x     = vel_q[0][31:0];
            res.vel_y     = vel_q[1][31:0];
            res.saturated = clipped_q;
            clipped_q = 1'b0;
            step_results_q.push_back(res);
         end
         gvb_pkg::OP_THRUST: begin
            heading_vector(sn, cs);
            acc_now_q[0] = clamp32(acc_now_q[0] + ((longint'(thrust_cfg) * sn) >>> 30));
            acc_now_q[1] = clamp32(acc_now_q[1] + ((longint'(thrust_cfg) * -cs) >>> 30));
         end
         gvb_pkg::OP_ROTATE: heading_q = heading_q + it.angle_delta;
         gvb_pkg::OP_RESTART: begin
            pos_q[0] = start_cfg[0];
            pos_q[1] = start_cfg[1];
            vel_q[0] = start_cfg[2];
            vel_q[1] = start_cfg[3];
            acc_now_q  = '{0, 0};
            acc_prev_q = '{0, 0};
            heading_q  = '0;
            clipped_q  = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // Receiver: random stalls, or a counted hold-off when a test asks for one.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 23);
      end
   end

   always @(posedge clock) begin
      gvb_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (step_results_q.size() == 0) begin
            errors++;
            if (mismatches < 10)
               $display("ERROR: unexpected step result %h at %0t", rsp_data, $realtime);
            mismatches++;
         end else begin
            want = step_results_q.pop_front();
            steps_checked++;
            if (rsp_data.pos_x !== want.pos_x || rsp_data.pos_y !== want.pos_y ||
                rsp_data.vel_x !== want.vel_x || rsp_data.vel_y !== want.vel_y ||
                rsp_data.saturated !== want.saturated) begin
               errors++;
               if (mismatches < 10) begin
                  $display("ERROR: step result mismatch at %0t", $realtime);
                  $display("  expected pos %h %h vel %h %h sat %b", want.pos_x, want.pos_y,
                           want.vel_x, want.vel_y, want.saturated);
                  $display("  actual   pos %h %h vel %h %h sat %b", rsp_data.pos_x,
                           rsp_data.pos_y, rsp_data.vel_x, rsp_data.vel_y,
                           rsp_data.saturated);
               end
               mismatches++;
            end
         end
      end
   end

   task automatic idle_sender();
      while (!calm && $urandom_range(99) < 23) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= gvb_pkg::req_type'(114'({$urandom, $urandom, $urandom, $urandom}));
         @(posedge clock);
      end
   endtask

   task automatic send_item(logic [2:0] op, logic [31:0] sx, logic [31:0] sy,
                            logic [30:0] mass, logic [15:0] delta);
      gvb_pkg::req_type it;
      it = '{operation: op, source_x: sx, source_y: sy, source_mass: mass,
             angle_delta: delta};
      idle_sender();
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_body(it);
      if (op <= gvb_pkg::OP_RESTART) items_sent++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      stop_sending();
      wait (step_results_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(gvb_pkg::csr_type idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         gvb_pkg::CSR_TIME_STEP:    dt_cfg     = value[30:0];
         gvb_pkg::CSR_GRAV_CONST:   grav_cfg   = value[30:0];
         gvb_pkg::CSR_THRUST_ACCEL: thrust_cfg = value[30:0];
         gvb_pkg::CSR_START_POS_X:  start_cfg[0] = longint'(signed'(value));
         gvb_pkg::CSR_START_POS_Y:  start_cfg[1] = longint'(signed'(value));
         gvb_pkg::CSR_START_VEL_X:  start_cfg[2] = longint'(signed'(value));
         gvb_pkg::CSR_START_VEL_Y:  start_cfg[3] = longint'(signed'(value));
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_setup(logic [30:0] dt, logic [30:0] grav, logic [30:0] thr,
                             logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                             logic [31:0] vy);
      write_reg(gvb_pkg::CSR_TIME_STEP, {1'b0, dt});
      write_reg(gvb_pkg::CSR_GRAV_CONST, {1'b0, grav});
      write_reg(gvb_pkg::CSR_THRUST_ACCEL, {1'b0, thr});
      write_reg(gvb_pkg::CSR_START_POS_X, px);
      write_reg(gvb_pkg::CSR_START_POS_Y, py);
      write_reg(gvb_pkg::CSR_START_VEL_X, vx);
      write_reg(gvb_pkg::CSR_START_VEL_Y, vy);
   endtask

   // Step with reset defaults: thrust straight ahead, then a turned heading.
   task automatic test_reset_defaults();
      send_item(gvb_pkg::OP_BEGIN_STEP, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_THRUST, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_END_STEP, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_ROTATE, '0, '0, '0, 16'h4000);
      send_item(gvb_pkg::OP_BEGIN_STEP, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_THRUST, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_END_STEP, '0, '0, '0, '0);
      wait_drained();
   endtask

   // Field extremes, zero distance, wide separation, unused codes and the fold of a heading below a quarter turn back.
   task automatic test_directed_corners();
      load_setup(31'd65536, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(gvb_pkg::OP_RESTART, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_BODY, pos_q[0][31:0], pos_q[1][31:0], 31'h7FFF_FFFF, '0);
      send_item(gvb_pkg::OP_BODY, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, '0);
      send_item(gvb_pkg::OP_BODY, 32'h0000_0001, 32'h0000_0000, 31'd0, '0);
      send_item(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
      send_item(3'd7, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_BEGIN_STEP, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_END_STEP, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_END_STEP, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_ROTATE, '0, '0, '0, 16'hFFFF);
      send_item(gvb_pkg::OP_THRUST, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_ROTATE, '0, '0, '0, 16'h8001);
      send_item(gvb_pkg::OP_THRUST, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_ROTATE, '0, '0, '0, 16'h4000);
      send_item(gvb_pkg::OP_THRUST, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_ROTATE, '0, '0, '0, 16'h0000);
      send_item(gvb_pkg::OP_END_STEP, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_RESTART, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_BODY, 32'h0001_0000, 32'h0001_0000, 31'h0001_0000, '0);
      send_item(gvb_pkg::OP_BEGIN_STEP, '0, '0, '0, '0);
      send_item(gvb_pkg::OP_END_STEP, '0, '0, '0, '0);
      wait_drained();
   endtask

   // Mostly well-formed steps with random content; the rest is noise.
   task automatic test_random_steps(int count);
      int target, ops, pick;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(99) < 85) begin
            if ($urandom_range(99) < 6) send_item(gvb_pkg::OP_RESTART, '0, '0, '0, '0);
            send_item(gvb_pkg::OP_BEGIN_STEP, $urandom, $urandom, 31'($urandom),
                      16'($urandom));
            ops = $urandom_range(3);
            for (int i = 0; i < ops; i++) begin
               pick = $urandom_range(9);
               if (pick < 3)
                  send_item(gvb_pkg::OP_BODY,
                            pos_q[0][31:0] + ($urandom >>> 10) - 32'h0020_0000,
                            pos_q[1][31:0] + ($urandom >>> 10) - 32'h0020_0000,
                            31'($urandom_range(32'h00FF_FFFF)), 16'($urandom));
               else if (pick < 4)
                  send_item(gvb_pkg::OP_BODY, $urandom, $urandom, 31'($urandom),
                            16'($urandom));
               else if (pick < 7)
                  send_item(gvb_pkg::OP_THRUST, $urandom, $urandom, 31'($urandom),
                            16'($urandom));
               else
                  send_item(gvb_pkg::OP_ROTATE, $urandom, $urandom, 31'($urandom),
                            16'($urandom));
            end
            send_item(gvb_pkg::OP_END_STEP, $urandom, $urandom, 31'($urandom),
                      16'($urandom));
         end else begin
            send_item(3'($urandom_range(7)), $urandom, $urandom, 31'($urandom),
                      16'($urandom));
         end
      end
      wait_drained();
   endtask

   // The receiver holds off while steps keep coming, so the unit backs up its input.
   task automatic test_result_holdoff();
      hold_left = 600;
      for (int i = 0; i < 6; i++) begin
         send_item(gvb_pkg::OP_BEGIN_STEP, '0, '0, '0, '0);
         send_item(gvb_pkg::OP_THRUST, '0, '0, '0, '0);
         send_item(gvb_pkg::OP_END_STEP, '0, '0, '0, '0);
      end
      wait_drained();
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      errors = 0; mismatches = 0; items_sent = 0; steps_checked = 0;
      hold_left = 0;
      calm = 1'b0;
      pos_q = '{0, 0}; vel_q = '{0, 0}; acc_now_q = '{0, 0}; acc_prev_q = '{0, 0};
      heading_q = '0; clipped_q = 1'b0;
      dt_cfg     = gvb_pkg::TIME_STEP_RST;
      grav_cfg   = gvb_pkg::GRAV_CONST_RST;
      thrust_cfg = gvb_pkg::THRUST_ACCEL_RST;
      start_cfg = '{0, 0, 0, 0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_directed_corners();
      load_setup(31'd1092, 31'd65536, 31'd3276800, 32'h0010_0000, 32'hFFF0_0000,
                 32'h0000_8000, 32'h0000_0000);
      test_random_steps(400);
      calm = 1'b1;
      test_random_steps(150);
      calm = 1'b0;
      load_setup(31'd0, 31'($urandom), 31'($urandom), $urandom, $urandom, $urandom,
                 $urandom);
      test_random_steps(250);
      load_setup(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      test_random_steps(200);
      load_setup(31'd65536, 31'($urandom_range(32'h0010_0000)),
                 31'($urandom_range(32'h0100_0000)),
                 $urandom, $urandom, $urandom >>> 8, $urandom >>> 8);
      test_random_steps(550);
      test_result_holdoff();

      $display("Summary: %0d items accepted, %0d step results checked", items_sent,
               steps_checked);
      $display("  across five register settings, including dt of zero and full scale.");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatching results", mismatches);
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Timeout with %0d step results outstanding", step_results_q.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/gvb_pkg.sv
design/gvb_iter.sv
design/gvb_dpath.sv
design/gvb_ctrl.sv
design/gravity_verlet_body_step_unit.sv
design/gvb_checker.sv
tb/sv/tb_gravity_verlet_body_step_unit.sv
